// File: rtl/quadratic_root_solver_core_assert.svh
// Assertion macros shared by the quadratic root solver RTL.
// Files that check their own logic include this header; it needs clk and rst_n in scope.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define QRS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define QRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs next-cycle check failed");

`endif

// File: rtl/qrs_pkg.sv
// Shared widths, result codes and stage sideband types for the quadratic root solver.
// No dependencies; every RTL module of the block imports it.
package qrs_pkg;

  localparam int CW    = 16;                // coefficient width
  localparam int FB    = 16;                // root fraction bits
  localparam int RW    = 35;                // root field width
  localparam int UW    = CW;                // coefficient magnitude
  localparam int QW    = 2 * CW + 1;        // discriminant width
  localparam int EW    = QW + 2 * FB;       // scaled discriminant
  localparam int NPAIR = (EW + 1) / 2;      // square root stages
  localparam int RTW   = NPAIR;             // square root width
  localparam int REMW  = RTW + 2;           // square root remainder
  localparam int MW    = CW + FB + 1;       // scaled -b
  localparam int NSW   = RTW + 2;           // numerator, also divider stages
  localparam int DW    = CW + 1;            // divisor (2|a| or |b|)
  localparam int IN_TW  = 3 * CW;
  localparam int OUT_TW = ((2 * RW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ALL  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  lin;
    logic                  neg_a;
    logic signed [MW-1:0]  mm;
    logic [NSW-1:0]        lin_n;
    logic                  lin_neg;
    logic [DW-1:0]         dvs;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
  } dv_side_t;

endpackage

// File: rtl/qrs_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Uses qrs_pkg; a sideband struct travels alongside each operand.
module qrs_isqrt import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [EW-1:0]    in_e,
  input  sq_side_t         in_side,
  output logic             out_v,
  output logic [RTW-1:0]   out_root,
  output logic             out_exact,
  output sq_side_t         out_side
);

  logic                  v_r    [1:NPAIR];
  logic [2*NPAIR-1:0]    e_r    [1:NPAIR];
  logic [RTW-1:0]        root_r [1:NPAIR];
  logic [REMW-1:0]       rem_r  [1:NPAIR];
  sq_side_t              side_r [1:NPAIR];

  for (genvar k = 0; k < NPAIR; k++) begin : g_stage
    logic              cur_v;
    logic [2*NPAIR-1:0] cur_e;
    logic [RTW-1:0]    cur_root;
    logic [REMW-1:0]   cur_rem;
    sq_side_t          cur_side;
    logic [1:0]        pair;
    logic [REMW-1:0]   shrem;
    logic [REMW-1:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_v    = in_v;
      assign cur_e    = (2*NPAIR)'(in_e);
      assign cur_root = '0;
      assign cur_rem  = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = v_r[k];
      assign cur_e    = e_r[k];
      assign cur_root = root_r[k];
      assign cur_rem  = rem_r[k];
      assign cur_side = side_r[k];
    end

    assign pair  = cur_e[2*(NPAIR-1-k)+1 -: 2];
    assign shrem = {cur_rem[REMW-3:0], pair};
    assign trial = {cur_root, 2'b01};
    assign ge    = shrem >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k+1]    <= cur_e;
        rem_r[k+1]  <= ge ? shrem - trial : shrem;
        root_r[k+1] <= {cur_root[RTW-2:0], ge};
        side_r[k+1] <= cur_side;
      end
    end
  end

  assign out_v     = v_r[NPAIR];
  assign out_root  = root_r[NPAIR];
  assign out_exact = (rem_r[NPAIR] == '0);
  assign out_side  = side_r[NPAIR];

endmodule

// File: rtl/qrs_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// Uses qrs_pkg; the dv_side_t sideband rides with each request.
module qrs_div import qrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [NSW-1:0]  in_n1,
  input  logic [NSW-1:0]  in_n2,
  input  logic [DW-1:0]   in_d,
  input  dv_side_t        in_side,
  output logic            out_v,
  output logic [NSW-1:0]  out_q1,
  output logic [NSW-1:0]  out_q2,
  output dv_side_t        out_side
);

  logic             v_r    [1:NSW];
  logic [DW-1:0]    rem1_r [1:NSW];
  logic [DW-1:0]    rem2_r [1:NSW];
  logic [NSW-1:0]   nq1_r  [1:NSW];
  logic [NSW-1:0]   nq2_r  [1:NSW];
  logic [DW-1:0]    d_r    [1:NSW];
  dv_side_t         side_r [1:NSW];

  for (genvar k = 0; k < NSW; k++) begin : g_stage
    logic           cur_v;
    logic [DW-1:0]  cur_rem1, cur_rem2, cur_d;
    logic [NSW-1:0] cur_nq1, cur_nq2;
    dv_side_t       cur_side;
    logic [DW:0]    t1, t2;
    logic           ge1, ge2;

    if (k == 0) begin : g_first
      assign cur_v    = in_v;
      assign cur_rem1 = '0;
      assign cur_rem2 = '0;
      assign cur_nq1  = in_n1;
      assign cur_nq2  = in_n2;
      assign cur_d    = in_d;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = v_r[k];
      assign cur_rem1 = rem1_r[k];
      assign cur_rem2 = rem2_r[k];
      assign cur_nq1  = nq1_r[k];
      assign cur_nq2  = nq2_r[k];
      assign cur_d    = d_r[k];
      assign cur_side = side_r[k];
    end

    // shift the next numerator bit into the partial remainder
    assign t1  = {cur_rem1, cur_nq1[NSW-1]};
    assign t2  = {cur_rem2, cur_nq2[NSW-1]};
    assign ge1 = t1 >= {1'b0, cur_d};
    assign ge2 = t2 >= {1'b0, cur_d};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem1_r[k+1] <= ge1 ? DW'(t1 - {1'b0, cur_d}) : DW'(t1);
        rem2_r[k+1] <= ge2 ? DW'(t2 - {1'b0, cur_d}) : DW'(t2);
        nq1_r[k+1]  <= {cur_nq1[NSW-2:0], ge1};
        nq2_r[k+1]  <= {cur_nq2[NSW-2:0], ge2};
        d_r[k+1]    <= cur_d;
        side_r[k+1] <= cur_side;
      end
    end
  end

  assign out_v    = v_r[NSW];
  assign out_q1   = nq1_r[NSW];
  assign out_q2   = nq2_r[NSW];
  assign out_side = side_r[NSW];

endmodule

// File: rtl/quadratic_root_solver_core.sv
// Quadratic root solver top level: coefficient front end, root pipeline, output skid stage.
// Uses qrs_pkg, qrs_isqrt, qrs_div and the assertion macros header.
//
// Usage:
//   Input channel in_*: one request holds coefficients a, b, c (signed, 16 bits each).
//   Output channel out_*: one result per request, in order: root_kind on out_tuser,
//   first_root and second_root (signed Q.16, truncated toward zero) on out_tdata.
//   Pipeline: from the input handshake to out_tvalid a request passes the 33 stages
//   of the square root pipeline and the 35 stages of the divider plus four
//   register stages of front end, root prep and output.
//   Throughput: one request per cycle while in_tready is high; every stage advances together.
//   Stall: when out_tready stays low, the output register holds its result and the
//   next finished result parks in the skid register; only then does in_tready drop,
//   and it rises again as soon as the skid register empties.
//   Reset (rst_n low, synchronous): clears all valid bits; the pipeline comes back
//   empty and in_tready is high in the first cycle after reset.
module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // coef_a, coef_b, coef_c
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // first_root, second_root, zero pad
  output logic [1:0]        out_tuser   // root_kind
);

  `include "quadratic_root_solver_core_assert.svh"

  localparam logic [NSW:0] LIM = (NSW+1)'(1) << (RW - 1);

  logic en;

  // stage 1: register coefficients and the two products
  logic                 v1_r;
  logic signed [CW-1:0] a1_r, b1_r, c1_r;
  logic [2*CW-1:0]      bb1_r, ac1_r;
  logic signed [CW-1:0] in_a, in_b, in_c;
  logic [UW-1:0]        in_ua, in_ub, in_uc;

  assign in_a  = in_tdata[CW-1:0];
  assign in_b  = in_tdata[2*CW-1:CW];
  assign in_c  = in_tdata[3*CW-1:2*CW];
  assign in_ua = in_a[CW-1] ? UW'(-in_a) : UW'(in_a);
  assign in_ub = in_b[CW-1] ? UW'(-in_b) : UW'(in_b);
  assign in_uc = in_c[CW-1] ? UW'(-in_c) : UW'(in_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= in_a;
      b1_r  <= in_b;
      c1_r  <= in_c;
      bb1_r <= in_ub * in_ub;
      ac1_r <= in_ua * in_uc;
    end
  end

  // stage 2: discriminant, classification, scaled -b (negated for negative a)
  logic                v2_r;
  logic [EW-1:0]       e2_r;
  sq_side_t            side2_r;
  logic [QW-1:0]       p_w, q4_w, disc_w;
  logic                opp, have;
  logic [UW-1:0]       ua2, ub2, uc2;
  logic signed [MW-1:0] bext;
  sq_side_t            side2_nxt;

  assign ua2    = a1_r[CW-1] ? UW'(-a1_r) : UW'(a1_r);
  assign ub2    = b1_r[CW-1] ? UW'(-b1_r) : UW'(b1_r);
  assign uc2    = c1_r[CW-1] ? UW'(-c1_r) : UW'(c1_r);
  assign p_w    = QW'(bb1_r);
  assign q4_w   = QW'({ac1_r, 2'b00});
  assign opp    = (c1_r == '0) || (a1_r[CW-1] != c1_r[CW-1]);
  assign have   = opp || (p_w >= q4_w);
  assign disc_w = opp ? p_w + q4_w : p_w - q4_w;
  assign bext   = MW'(b1_r);

  always_comb begin
    side2_nxt.lin     = (a1_r == '0);
    side2_nxt.neg_a   = a1_r[CW-1];
    side2_nxt.mm      = (a1_r[CW-1] ? bext : -bext) <<< FB;
    side2_nxt.lin_n   = NSW'(uc2) << FB;
    side2_nxt.lin_neg = (c1_r[CW-1] == b1_r[CW-1]);
    side2_nxt.dvs     = (a1_r == '0) ? DW'(ub2) : {ua2, 1'b0};
    if (a1_r == '0) begin
      if (b1_r == '0) begin
        side2_nxt.kind = (c1_r == '0) ? KIND_ALL : KIND_NONE;
      end else begin
        side2_nxt.kind = KIND_ONE;
      end
    end else if (!have) begin
      side2_nxt.kind = KIND_NONE;
    end else if (disc_w == '0) begin
      side2_nxt.kind = KIND_ONE;
    end else begin
      side2_nxt.kind = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_r    <= (have && a1_r != '0) ? EW'(disc_w) << (2 * FB) : '0;
      side2_r <= side2_nxt;
    end
  end

  // square root pipeline
  logic            sq_v, sq_exact;
  logic [RTW-1:0]  sq_root;
  sq_side_t        sq_side;

  qrs_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (v2_r),
    .in_e      (e2_r),
    .in_side   (side2_r),
    .out_v     (sq_v),
    .out_root  (sq_root),
    .out_exact (sq_exact),
    .out_side  (sq_side)
  );

  // stage 3: numerator magnitudes and signs for both branches
  logic signed [NSW-1:0] rs, mms, upv, fp, cem, fm;
  logic [NSW-1:0]        np, nm;
  logic                  negp, negm;
  logic                  v3_r;
  logic [NSW-1:0]        n1_3_r, n2_3_r;
  logic [DW-1:0]         d3_r;
  dv_side_t              dside3_r;

  assign rs   = $signed({2'b00, sq_root});
  assign mms  = NSW'(sq_side.mm);
  assign upv  = $signed({{(NSW-1){1'b0}}, ~sq_exact});
  assign fp   = mms + rs;
  assign cem  = mms - rs;
  assign fm   = cem - upv;
  assign negp = fp[NSW-1];
  assign negm = fm[NSW-1];
  assign np   = negp ? NSW'(-(fp + upv)) : NSW'(fp);
  assign nm   = negm ? NSW'(-cem) : NSW'(fm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r          <= sq_side.dvs;
      dside3_r.kind <= sq_side.kind;
      if (sq_side.lin) begin
        n1_3_r        <= sq_side.lin_n;
        dside3_r.neg1 <= sq_side.lin_neg;
      end else begin
        n1_3_r        <= sq_side.neg_a ? nm : np;
        dside3_r.neg1 <= sq_side.neg_a ? negm : negp;
      end
      n2_3_r        <= sq_side.neg_a ? np : nm;
      dside3_r.neg2 <= sq_side.neg_a ? negp : negm;
    end
  end

  // divider pipeline
  logic           dv_v;
  logic [NSW-1:0] dv_q1, dv_q2;
  dv_side_t       dv_side;

  qrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v3_r),
    .in_n1    (n1_3_r),
    .in_n2    (n2_3_r),
    .in_d     (d3_r),
    .in_side  (dside3_r),
    .out_v    (dv_v),
    .out_q1   (dv_q1),
    .out_q2   (dv_q2),
    .out_side (dv_side)
  );

  function automatic logic [RW-1:0] sat_root(input logic [NSW-1:0] q, input logic neg);
    logic [NSW:0] qx;
    qx = {1'b0, q};
    if (neg) begin
      sat_root = (qx > LIM) ? {1'b1, {(RW-1){1'b0}}} : RW'(-qx);
    end else begin
      sat_root = (qx > LIM - 1) ? {1'b0, {(RW-1){1'b1}}} : RW'(qx);
    end
  endfunction

  logic [RW-1:0] r1_w, r2_w;

  assign r1_w = (dv_side.kind == KIND_ONE || dv_side.kind == KIND_TWO) ?
                sat_root(dv_q1, dv_side.neg1) : '0;
  assign r2_w = (dv_side.kind == KIND_TWO) ? sat_root(dv_q2, dv_side.neg2) : '0;

  // output register with skid stage
  logic          out_v_r, skid_v_r;
  kind_t         kind_r, skid_kind_r;
  logic [RW-1:0] r1_r, r2_r, skid_r1_r, skid_r2_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= dv_v;
      end
    end else if (dv_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        kind_r <= skid_kind_r;
        r1_r   <= skid_r1_r;
        r2_r   <= skid_r2_r;
      end else begin
        kind_r <= dv_side.kind;
        r1_r   <= r1_w;
        r2_r   <= r2_w;
      end
    end else if (!skid_v_r) begin
      skid_kind_r <= dv_side.kind;
      skid_r1_r   <= r1_w;
      skid_r2_r   <= r2_w;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = OUT_TW'({r2_r, r1_r});

  `QRS_ASSERT_IMPLY(a_skid_behind_out, skid_v_r, out_v_r)
  `QRS_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_tready, skid_v_r && out_v_r)
  `QRS_ASSERT_IMPLY(a_first_unused_zero, out_v_r && (kind_r == KIND_NONE || kind_r == KIND_ALL), r1_r == '0)
  `QRS_ASSERT_IMPLY(a_second_unused_zero, out_v_r && kind_r != KIND_TWO, r2_r == '0)

endmodule

// File: sim/qrs_root_checker.sv
// Checker for the quadratic root solver: watches both stream channels, predicts each result.
// Depends on qrs_pkg for the result kind codes and the port widths.
`timescale 1ns / 100ps

module qrs_root_checker import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // coef_a, coef_b, coef_c
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_TW-1:0] out_tdata,  // first_root, second_root, zero pad
  input  logic [1:0]        out_tuser,  // root_kind
  output int                fail_count,
  output int                pending_roots,
  output int                checked_roots
);

  typedef struct packed {
    kind_t                kind;
    logic signed [RW-1:0] first;
    logic signed [RW-1:0] second;
  } roots_t;

  roots_t expected_roots[$];

  function automatic logic signed [RW-1:0] clamp_root(longint q);
    longint lim;
    lim = longint'(1) <<< (RW - 1);
    if (q > lim - 1) q = lim - 1;
    if (q < -lim) q = -lim;
    return q[RW-1:0];
  endfunction

  // Floor square root of a wide value, two bits per step.
  function automatic logic [63:0] floor_sqrt(logic [127:0] e, output bit exact);
    logic [63:0]  root;
    logic [127:0] rem;
    logic [127:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | ((e >> (2 * i)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    exact = (rem == 0);
    return root;
  endfunction

  // Truncate (m + dir*sqrt(E)) / d toward zero, given r = floor(sqrt(E)).
  function automatic longint trunc_branch(longint m, int dir, longint r, bit exact, longint d);
    longint fl, ce, up;
    up = exact ? 0 : 1;
    if (dir > 0) begin
      fl = m + r;
      ce = fl + up;
    end else begin
      ce = m - r;
      fl = ce - up;
    end
    return (fl >= 0) ? fl / d : ce / d;
  endfunction

  function automatic roots_t solve_roots(logic [IN_TW-1:0] coefs);
    roots_t res;
    longint a, b, c, s, d, mm, disc;
    logic [63:0] r;
    bit exact;
    int dp;
    a = longint'($signed(coefs[CW-1:0]));
    b = longint'($signed(coefs[2*CW-1:CW]));
    c = longint'($signed(coefs[3*CW-1:2*CW]));
    s = longint'(1) <<< FB;
    res.kind = KIND_NONE;
    res.first = '0;
    res.second = '0;
    if (a == 0) begin
      if (b == 0) begin
        res.kind = (c == 0) ? KIND_ALL : KIND_NONE;
      end else begin
        res.kind = KIND_ONE;
        res.first = clamp_root((-c * s) / b);
      end
    end else begin
      d = 2 * ((a < 0) ? -a : a);
      mm = (a < 0) ? b * s : -b * s;
      disc = b * b - 4 * a * c;
      if (disc == 0) begin
        res.kind = KIND_ONE;
        res.first = clamp_root(trunc_branch(mm, 1, 0, 1'b1, d));
      end else if (disc > 0) begin
        r = floor_sqrt({64'd0, disc} << (2 * FB), exact);
        dp = (a < 0) ? -1 : 1;
        res.kind = KIND_TWO;
        res.first = clamp_root(trunc_branch(mm, dp, longint'(r), exact, d));
        res.second = clamp_root(trunc_branch(mm, -dp, longint'(r), exact, d));
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    checked_roots = 0;
    pending_roots = 0;
  end

  always @(posedge clk) begin
    roots_t want;
    logic [OUT_TW-1:0] want_data;
    if (rst_n && in_tvalid && in_tready)
      expected_roots.push_back(solve_roots(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      checked_roots <= checked_roots + 1;
      if (expected_roots.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10)
          $display("%0t: result with nothing pending: kind %0d data %h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = expected_roots.pop_front();
        want_data = '0;
        want_data[RW-1:0] = want.first;
        want_data[2*RW-1:RW] = want.second;
        if (out_tuser !== want.kind || out_tdata !== want_data) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: mismatch: kind exp %0d got %0d, first exp %0d got %0d, second exp %0d got %0d, pad got %h",
                     $time, want.kind, out_tuser, want.first, $signed(out_tdata[RW-1:0]),
                     want.second, $signed(out_tdata[2*RW-1:RW]), out_tdata[OUT_TW-1:2*RW]);
        end
      end
    end
    pending_roots = expected_roots.size();
  end

endmodule

// File: sim/tb_quadratic_root_solver_core.sv
// Testbench top for quadratic_root_solver_core: clock, reset, coefficient stimulus, verdict.
// Depends on qrs_pkg, the RTL and qrs_root_checker.
`timescale 1ns / 100ps

module tb_quadratic_root_solver_core;
  import qrs_pkg::*;

  localparam int RANDOM_SETS = 1600;
  localparam int CALM_FROM   = 1400;   // no idling from here on
  localparam int STALL_AT    = 300;
  localparam int DRAIN_AT    = 900;
  localparam int IDLE_LIMIT  = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic [1:0]        out_tuser;
  int                fail_count, pending_roots, checked_roots;
  int                sent_sets = 0;
  int                idle_cycles = 0;
  bit                long_stall_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadratic_root_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  qrs_root_checker root_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_roots(pending_roots), .checked_roots(checked_roots)
  );

  // Offer one coefficient set from a falling edge; return at the falling edge after acceptance.
  task automatic offer_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    in_tvalid <= 1'b1;
    in_tdata <= {c, b, a};
    do @(posedge clk); while (!in_tready);
    sent_sets++;
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (sent_sets < CALM_FROM && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic random_coefs();
    int p, q, k;
    logic [CW-1:0] a, b, c;
    case ($urandom_range(0, 9))
      0, 1: begin
        a = '0;
        b = ($urandom_range(0, 3) == 0) ? '0 : CW'($urandom);
        c = ($urandom_range(0, 3) == 0) ? '0 : CW'($urandom);
      end
      2, 3, 4: begin
        a = CW'($urandom_range(0, 40) - 20);
        b = CW'($urandom_range(0, 40) - 20);
        c = CW'($urandom_range(0, 40) - 20);
      end
      5, 6: begin
        // build from integer roots so the discriminant is often a perfect square
        p = $urandom_range(0, 60) - 30;
        q = ($urandom_range(0, 2) == 0) ? p : $urandom_range(0, 60) - 30;
        k = $urandom_range(1, 30) * (($urandom_range(0, 1) == 0) ? 1 : -1);
        a = CW'(k);
        b = CW'(-k * (p + q));
        c = CW'(k * p * q);
      end
      default: begin
        a = CW'($urandom);
        b = CW'($urandom);
        c = CW'($urandom);
      end
    endcase
    offer_coefs(a, b, c);
  endtask

  // Receiver: random stall bursts, one long hold-off, always ready near the end.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_stall_done && sent_sets >= STALL_AT) begin
        long_stall_done = 1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        out_tready <= 1'b1;
      end else if (sent_sets < CALM_FROM && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("tb_quadratic_root_solver_core: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: every kind, field extremes, double root, exact and inexact roots
    offer_coefs(16'd0, 16'd0, 16'd0);
    offer_coefs(16'd0, 16'd0, 16'd5);
    offer_coefs(16'd0, 16'd0, 16'h8000);
    offer_coefs(16'd0, 16'd3, 16'd7);
    offer_coefs(16'd0, 16'h8000, 16'h7fff);
    offer_coefs(16'd0, 16'd1, 16'h8000);
    offer_coefs(16'd0, 16'hffff, 16'h7fff);
    offer_coefs(16'd1, 16'd2, 16'd1);
    offer_coefs(16'hffff, 16'd2, 16'hffff);
    offer_coefs(16'd1, 16'd0, 16'd1);
    offer_coefs(16'd1, 16'd0, 16'hfffc);
    offer_coefs(16'hfffd, 16'd7, 16'd11);
    offer_coefs(16'd5, 16'hfff7, 16'd0);
    offer_coefs(16'd1, 16'h8000, 16'd0);
    offer_coefs(16'h8000, 16'h8000, 16'h8000);
    offer_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    offer_coefs(16'h8000, 16'h7fff, 16'h7fff);
    offer_coefs(16'h7fff, 16'h8000, 16'h8000);
    offer_coefs(16'd1, 16'h7fff, 16'h8000);
    offer_coefs(16'h8000, 16'd0, 16'h7fff);
    offer_coefs(16'hffff, 16'hffff, 16'hffff);
    offer_coefs(16'd1, 16'd0, 16'hfffe);
    offer_coefs(16'd3, 16'd1, 16'h8000);
    for (int n = 0; n < RANDOM_SETS; n++) begin
      if (n == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        wait (pending_roots == 0);
        @(negedge clk);
      end
      random_coefs();
      maybe_gap();
    end
    in_tvalid <= 1'b0;
    wait (pending_roots == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d coefficient sets (directed extremes, linear, double, two-root, none, all)",
             sent_sets);
    $display("checked %0d results, with random stalls, one long output hold-off and a drain",
             checked_roots);
    if (fail_count == 0 && pending_roots == 0)
      $display("tb_quadratic_root_solver_core: PASS");
    else
      $display("tb_quadratic_root_solver_core: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_isqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_core.sv
sim/qrs_root_checker.sv
sim/tb_quadratic_root_solver_core.sv
